/* rtl/source_tokenizer_core_assert.svh */
// Assertion macros for the tokenizer checker.
`ifndef SOURCE_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_TOKENIZER_CORE_ASSERT_SVH

// Check in the same cycle: the consequent must hold whenever the antecedent does.
`define STT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check in the next cycle.
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/stt_pkg.sv */
// Shared types and constants of the source tokenizer.
`default_nettype none

package stt_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_SLASH  = 3'd3,
        MODE_LINE   = 3'd4,
        MODE_BLOCK  = 3'd5,
        MODE_STAR   = 3'd6
    } scan_mode_t;

    typedef enum logic [3:0] {
        TK_IDENT    = 4'd0,
        TK_VAR      = 4'd1,
        TK_FUNCTION = 4'd2,
        TK_RETURN   = 4'd3,
        TK_PRINT    = 4'd4,
        TK_INT      = 4'd5,
        TK_INTEGER  = 4'd6,
        TK_LPAREN   = 4'd7,
        TK_RPAREN   = 4'd8,
        TK_LBRACE   = 4'd9,
        TK_RBRACE   = 4'd10,
        TK_COMMA    = 4'd11,
        TK_SEMI     = 4'd12,
        TK_ASSIGN   = 4'd13,
        TK_EOF      = 4'd14,
        TK_ERROR    = 4'd15
    } token_kind_t;

    // Byte offset wraps at OFF_W bits; line, column and length saturate at CNT_W bits.
    localparam int OFF_W  = 24;
    localparam int CNT_W  = 16;
    localparam int LINE_W = CNT_W;
    localparam int COL_W  = CNT_W;
    localparam int LEN_W  = CNT_W;
    localparam int BAD_W  = 8;

    // Bit positions of the fields in the output tdata word.
    localparam int TD_OFF_LO  = 0;
    localparam int TD_LINE_LO = TD_OFF_LO + OFF_W;
    localparam int TD_COL_LO  = TD_LINE_LO + LINE_W;
    localparam int TD_LEN_LO  = TD_COL_LO + COL_W;
    localparam int TD_BAD_LO  = TD_LEN_LO + LEN_W;
    localparam int TD_W       = TD_BAD_LO + BAD_W;

    typedef struct packed {
        token_kind_t         kind;
        logic [OFF_W-1:0]    offset;
        logic [LINE_W-1:0]   line;
        logic [COL_W-1:0]    column;
        logic [LEN_W-1:0]    length;
        logic [BAD_W-1:0]    bad;
    } tok_rec_t;

    localparam int GROUP_MAX = 3;

    // Tokens caused by one input word, compacted from slot 0 up.
    typedef struct packed {
        tok_rec_t [GROUP_MAX-1:0] rec;
        logic [1:0]               cnt;
    } tok_group_t;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

/* rtl/stt_queue.sv */
// Token group queue between the scanner and the output stage.
`default_nettype none

module stt_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire stt_pkg::tok_group_t push_data,
    input  wire logic                pop,
    output stt_pkg::tok_group_t      head,
    output stt_pkg::q_stat_t         stat
);

    stt_pkg::tok_group_t                 entry_reg [stt_pkg::QDEPTH];
    logic [stt_pkg::QPTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [stt_pkg::QPTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [stt_pkg::QCNT_W-1:0]          cnt_reg, cnt_next;
    logic                                do_push, do_pop;

    assign stat.full  = (cnt_reg == stt_pkg::QCNT_W'(stt_pkg::QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/stt_front.sv */
// Scanner: classifies each source byte, tracks position and builds token groups.
`default_nettype none

module stt_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       char_code,
    input  wire logic             has_char,
    input  wire logic             is_end,
    output logic                  push,
    output stt_pkg::tok_group_t   push_data
);

    localparam int OFFSET_BITS = stt_pkg::OFF_W;
    localparam int COUNT_BITS  = stt_pkg::CNT_W;

    localparam logic [COUNT_BITS-1:0]  CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0]  CNT_ONE = COUNT_BITS'(1);

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_US    = 8'h5F;

    localparam logic [63:0] KW_VAR      = 64'h0000_0000_0076_6172;
    localparam logic [63:0] KW_FUNCTION = 64'h6675_6E63_7469_6F6E;
    localparam logic [63:0] KW_RETURN   = 64'h0000_7265_7475_726E;
    localparam logic [63:0] KW_PRINT    = 64'h0000_0070_7269_6E74;
    localparam logic [63:0] KW_INT      = 64'h0000_0000_0069_6E74;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [7:0] to_lower(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

    function automatic stt_pkg::token_kind_t punct_kind(logic [7:0] c);
        stt_pkg::token_kind_t k;
        unique case (c)
            8'h28:   k = stt_pkg::TK_LPAREN;
            8'h29:   k = stt_pkg::TK_RPAREN;
            8'h7B:   k = stt_pkg::TK_LBRACE;
            8'h7D:   k = stt_pkg::TK_RBRACE;
            8'h2C:   k = stt_pkg::TK_COMMA;
            8'h3B:   k = stt_pkg::TK_SEMI;
            8'h3D:   k = stt_pkg::TK_ASSIGN;
            default: k = stt_pkg::TK_ERROR;
        endcase
        return k;
    endfunction

    // Keywords need the exact length, so longer identifiers never match.
    function automatic stt_pkg::token_kind_t ident_kind(logic [63:0] kb,
                                                        logic [COUNT_BITS-1:0] n);
        stt_pkg::token_kind_t k;
        priority if (n == COUNT_BITS'(3) && kb == KW_VAR)
            k = stt_pkg::TK_VAR;
        else if (n == COUNT_BITS'(8) && kb == KW_FUNCTION)
            k = stt_pkg::TK_FUNCTION;
        else if (n == COUNT_BITS'(6) && kb == KW_RETURN)
            k = stt_pkg::TK_RETURN;
        else if (n == COUNT_BITS'(5) && kb == KW_PRINT)
            k = stt_pkg::TK_PRINT;
        else if (n == COUNT_BITS'(3) && kb == KW_INT)
            k = stt_pkg::TK_INT;
        else
            k = stt_pkg::TK_IDENT;
        return k;
    endfunction

    function automatic stt_pkg::tok_rec_t make_rec(stt_pkg::token_kind_t k,
                                                   logic [OFFSET_BITS-1:0] o,
                                                   logic [COUNT_BITS-1:0] l,
                                                   logic [COUNT_BITS-1:0] col,
                                                   logic [COUNT_BITS-1:0] n,
                                                   logic [7:0] b);
        stt_pkg::tok_rec_t r;
        logic [31:0] o32, l32, c32, n32;
        o32      = 32'(o);
        l32      = 32'(l);
        c32      = 32'(col);
        n32      = 32'(n);
        r.kind   = k;
        r.offset = o32[stt_pkg::OFF_W-1:0];
        r.line   = l32[stt_pkg::LINE_W-1:0];
        r.column = c32[stt_pkg::COL_W-1:0];
        r.length = n32[stt_pkg::LEN_W-1:0];
        r.bad    = b;
        return r;
    endfunction

    stt_pkg::scan_mode_t          mode_reg, mode_next;
    logic [OFFSET_BITS-1:0]       off_reg, off_next;
    logic [COUNT_BITS-1:0]        line_reg, line_next;
    logic [COUNT_BITS-1:0]        col_reg, col_next;
    logic [OFFSET_BITS-1:0]       ts_off_reg, ts_off_next;
    logic [COUNT_BITS-1:0]        ts_line_reg, ts_line_next;
    logic [COUNT_BITS-1:0]        ts_col_reg, ts_col_next;
    logic [COUNT_BITS-1:0]        tlen_reg, tlen_next;
    logic [63:0]                  kbuf_reg, kbuf_next;

    logic                         va, vb, vc, vd, vm, go_idle, c_word, c_space;
    stt_pkg::token_kind_t         pk;
    stt_pkg::tok_rec_t            rec_a, rec_b, rec_c, rec_d, rec_m;

    always_comb
    begin
        mode_next    = mode_reg;
        off_next     = off_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        ts_off_next  = ts_off_reg;
        ts_line_next = ts_line_reg;
        ts_col_next  = ts_col_reg;
        tlen_next    = tlen_reg;
        kbuf_next    = kbuf_reg;
        va           = 1'b0;
        vb           = 1'b0;
        vc           = 1'b0;
        vd           = is_end;
        go_idle      = 1'b0;
        c_word       = is_alpha(char_code) || is_digit(char_code) || char_code == CH_US;
        c_space      = char_code == CH_SPACE || char_code == CH_TAB ||
                       char_code == CH_CR || char_code == CH_LF;
        pk           = punct_kind(char_code);
        rec_a        = make_rec(stt_pkg::TK_INTEGER, ts_off_reg, ts_line_reg, ts_col_reg,
                                tlen_reg, 8'h00);
        rec_b        = make_rec(pk, off_reg, line_reg, col_reg, CNT_ONE,
                                (pk == stt_pkg::TK_ERROR) ? char_code : 8'h00);
        rec_c        = make_rec(stt_pkg::TK_INTEGER, ts_off_reg, ts_line_reg, ts_col_reg,
                                tlen_reg, 8'h00);
        rec_d        = make_rec(stt_pkg::TK_EOF, off_reg, line_reg, col_reg, '0, 8'h00);

        if (has_char)
        begin
            unique case (mode_reg)
                stt_pkg::MODE_IDENT:
                begin
                    if (c_word)
                    begin
                        tlen_next = sat_inc(tlen_reg);
                        kbuf_next = {kbuf_reg[55:0], to_lower(char_code)};
                    end
                    else
                    begin
                        va         = 1'b1;
                        rec_a.kind = ident_kind(kbuf_reg, tlen_reg);
                        go_idle    = 1'b1;
                    end
                end
                stt_pkg::MODE_NUMBER:
                begin
                    if (is_digit(char_code))
                    begin
                        tlen_next = sat_inc(tlen_reg);
                    end
                    else
                    begin
                        va      = 1'b1;
                        go_idle = 1'b1;
                    end
                end
                stt_pkg::MODE_SLASH:
                begin
                    if (char_code == CH_SLASH)
                    begin
                        mode_next = stt_pkg::MODE_LINE;
                    end
                    else if (char_code == CH_STAR)
                    begin
                        mode_next = stt_pkg::MODE_BLOCK;
                    end
                    else
                    begin
                        // lone slash: report it at its own position
                        va         = 1'b1;
                        rec_a      = make_rec(stt_pkg::TK_ERROR, ts_off_reg, ts_line_reg,
                                              ts_col_reg, CNT_ONE, CH_SLASH);
                        go_idle    = 1'b1;
                    end
                end
                stt_pkg::MODE_LINE:
                begin
                    if (char_code == CH_LF)
                    begin
                        mode_next = stt_pkg::MODE_IDLE;
                    end
                end
                stt_pkg::MODE_BLOCK:
                begin
                    if (char_code == CH_STAR)
                    begin
                        mode_next = stt_pkg::MODE_STAR;
                    end
                end
                stt_pkg::MODE_STAR:
                begin
                    if (char_code == CH_SLASH)
                    begin
                        mode_next = stt_pkg::MODE_IDLE;
                    end
                    else if (char_code != CH_STAR)
                    begin
                        mode_next = stt_pkg::MODE_BLOCK;
                    end
                end
                default:
                begin
                    go_idle = 1'b1;
                end
            endcase

            // rescan the byte from idle
            if (go_idle)
            begin
                mode_next = stt_pkg::MODE_IDLE;
                if (c_space)
                begin
                    mode_next = stt_pkg::MODE_IDLE;
                end
                else if (is_alpha(char_code) || char_code == CH_US ||
                         is_digit(char_code) || char_code == CH_SLASH)
                begin
                    ts_off_next  = off_reg;
                    ts_line_next = line_reg;
                    ts_col_next  = col_reg;
                    tlen_next    = CNT_ONE;
                    if (is_digit(char_code))
                    begin
                        mode_next = stt_pkg::MODE_NUMBER;
                    end
                    else if (char_code == CH_SLASH)
                    begin
                        mode_next = stt_pkg::MODE_SLASH;
                    end
                    else
                    begin
                        mode_next = stt_pkg::MODE_IDENT;
                        kbuf_next = 64'(to_lower(char_code));
                    end
                end
                else
                begin
                    vb = 1'b1;
                end
            end

            if (char_code == CH_LF)
            begin
                line_next = sat_inc(line_reg);
                col_next  = CNT_ONE;
            end
            else
            begin
                col_next = sat_inc(col_reg);
            end
            off_next = off_reg + 1'b1;
        end

        if (is_end)
        begin
            rec_c = make_rec(stt_pkg::TK_INTEGER, ts_off_next, ts_line_next, ts_col_next,
                             tlen_next, 8'h00);
            rec_d = make_rec(stt_pkg::TK_EOF, off_next, line_next, col_next, '0, 8'h00);
            unique case (mode_next)
                stt_pkg::MODE_IDENT:
                begin
                    vc         = 1'b1;
                    rec_c.kind = ident_kind(kbuf_next, tlen_next);
                end
                stt_pkg::MODE_NUMBER:
                begin
                    vc = 1'b1;
                end
                stt_pkg::MODE_SLASH:
                begin
                    vc = 1'b1;
                    rec_c = make_rec(stt_pkg::TK_ERROR, ts_off_next, ts_line_next,
                                     ts_col_next, CNT_ONE, CH_SLASH);
                end
                default:
                begin
                    vc = 1'b0;
                end
            endcase

            // end of source: back to the reset state
            mode_next    = stt_pkg::MODE_IDLE;
            off_next     = '0;
            line_next    = CNT_ONE;
            col_next     = CNT_ONE;
            ts_off_next  = '0;
            ts_line_next = CNT_ONE;
            ts_col_next  = CNT_ONE;
            tlen_next    = '0;
            kbuf_next    = '0;
        end
    end

    // A byte emission and an end-of-source pending token never occur together.
    assign vm    = vb || vc;
    assign rec_m = vb ? rec_b : rec_c;

    always_comb
    begin
        push_data.rec[0] = va ? rec_a : (vm ? rec_m : rec_d);
        push_data.rec[1] = va ? (vm ? rec_m : rec_d) : rec_d;
        push_data.rec[2] = rec_d;
        push_data.cnt    = 2'(va) + 2'(vm) + 2'(vd);
    end

    assign push = accept && (va || vm || vd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= stt_pkg::MODE_IDLE;
            off_reg     <= '0;
            line_reg    <= CNT_ONE;
            col_reg     <= CNT_ONE;
            ts_off_reg  <= '0;
            ts_line_reg <= CNT_ONE;
            ts_col_reg  <= CNT_ONE;
            tlen_reg    <= '0;
            kbuf_reg    <= '0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            off_reg     <= off_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            ts_off_reg  <= ts_off_next;
            ts_line_reg <= ts_line_next;
            ts_col_reg  <= ts_col_next;
            tlen_reg    <= tlen_next;
            kbuf_reg    <= kbuf_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/stt_back.sv */
// Output stage: drains token groups into a registered master port, one word per cycle while it is not stalled.
`default_nettype none

module stt_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire stt_pkg::tok_group_t         head,
    input  wire stt_pkg::q_stat_t            q_stat,
    output logic                             pop,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [stt_pkg::TD_W-1:0]         m_axis_tdata,
    output logic [3:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);

    logic [1:0]            idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_last_reg;
    stt_pkg::tok_rec_t     out_rec_reg;
    stt_pkg::tok_rec_t     cur_rec;
    logic                  load, is_last;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    cur_rec = head.rec[0];
            2'd1:    cur_rec = head.rec[1];
            default: cur_rec = head.rec[2];
        endcase
    end

    assign load    = !q_stat.empty && (!out_valid_reg || m_axis_tready);
    assign is_last = (idx_reg == head.cnt - 2'd1);
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_rec_reg  <= cur_rec;
            out_last_reg <= is_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_rec_reg.kind;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {out_rec_reg.bad, out_rec_reg.length, out_rec_reg.column,
                            out_rec_reg.line, out_rec_reg.offset};

endmodule

`default_nettype wire

/* rtl/source_tokenizer_core.sv */
// Source tokenizer top level: byte stream in, token records out.
// Takes one source byte per cycle; s_axis_tready is high whenever the four-entry
// token queue has room, so bytes stream back to back. Each word produces zero to
// three tokens; the output stage sends one token per cycle while the master port
// is ready, and the queue absorbs the bursts of a word that causes two or three
// tokens. A token passes through the token queue and the registered output stage
// before it is valid on the master port. Whitespace and comments produce no tokens;
// the end of each source (tlast on input) emits any pending token and an
// end-of-file token, then restarts the offset, line and column counters.
`default_nettype none

module source_tokenizer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tuser,   // [0] has_char
    input  wire logic        s_axis_tlast,   // is_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // [23:0] start_offset, [39:24] start_line,
                                             // [55:40] start_column, [71:56] token_length,
                                             // [79:72] bad_char
    output logic [3:0]       m_axis_tuser,   // [3:0] token_kind
    output logic             m_axis_tlast    // last_of_run
);

    logic                  accept, push, pop;
    stt_pkg::tok_group_t   push_data, head;
    stt_pkg::q_stat_t      q_stat;

    assign s_axis_tready = !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    stt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (s_axis_tdata),
        .has_char  (s_axis_tuser),
        .is_end    (s_axis_tlast),
        .push      (push),
        .push_data (push_data)
    );

    stt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    stt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* rtl/stt_checker.sv */
// Port-level checker for the source tokenizer, bound to the top level.
`default_nettype none

`include "source_tokenizer_core_assert.svh"

module stt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata,
    input wire logic [3:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    logic [15:0] len_f, line_f, col_f;
    logic [7:0]  bad_f;

    assign len_f   = m_axis_tdata[stt_pkg::TD_LEN_LO +: stt_pkg::LEN_W];
    assign line_f  = m_axis_tdata[stt_pkg::TD_LINE_LO +: stt_pkg::LINE_W];
    assign col_f   = m_axis_tdata[stt_pkg::TD_COL_LO +: stt_pkg::COL_W];
    assign bad_f   = m_axis_tdata[stt_pkg::TD_BAD_LO +: stt_pkg::BAD_W];

    // hold a stalled word
    `STT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
        "stalled output word changed")

    `STT_ASSERT_NOW(a_eof_shape, m_axis_tvalid && m_axis_tuser == stt_pkg::TK_EOF,
        len_f == 16'h0000 && m_axis_tlast && bad_f == 8'h00,
        "end-of-file token must be last, empty and carry no byte")

    `STT_ASSERT_NOW(a_bad_only_error, m_axis_tvalid && m_axis_tuser != stt_pkg::TK_ERROR,
        bad_f == 8'h00, "bad_char set on a non-error token")

    `STT_ASSERT_NOW(a_pos_nonzero, m_axis_tvalid,
        line_f != 16'h0000 && col_f != 16'h0000, "line or column reached zero")

endmodule

bind source_tokenizer_core stt_checker u_stt_checker (.*);

`default_nettype wire
